// ----- hw/rtl/pfe_pkg.sv -----
// Shared constants, codes and types of the postfix expression evaluator.
`timescale 1ns / 1ps

package pfe_pkg;

	localparam int STACK_DEPTH    = 128;
	localparam int SP_W           = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W         = $clog2(STACK_DEPTH);
	localparam int DATA_W         = 32;
	localparam int CMD_FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W     = $clog2(CMD_FIFO_DEPTH);
	localparam int FIFO_CNT_W     = $clog2(CMD_FIFO_DEPTH + 1);
	localparam int DIV_CNT_W      = $clog2(DATA_W + 1);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [1:0] ERR_OK        = 2'd0;
	localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
	localparam logic [1:0] ERR_DIVZERO   = 2'd3;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_expression;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [1:0]               error_code;
	} out_item_t;

	typedef struct packed {
		logic              push_valid;
		logic [DATA_W-1:0] push_value;
		op_t               op;
		logic              end_flag;
	} cmd_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ----- hw/rtl/postfix_expression_evaluator.sv -----
// A closing character gives its result later when commands are queued ahead of it; an
// operator adds to the wait, and a division also waits on the divider.
// The front takes one character per cycle while its 4-entry command queue has room; the stack
// engine takes a command in its idle state, then runs its push, operand read, execute, divide and end states as needed.
// Reset (arst_n low) clears stack pointer, number, error, queue and result; the stack RAM is
// not cleared, as only entries below the stack pointer are ever read.
`timescale 1ns / 1ps

module postfix_expression_evaluator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  pfe_pkg::in_item_t  expr_char,
	output logic               empty,
	input  logic               pop,
	output pfe_pkg::out_item_t result
);

	import pfe_pkg::*;

	logic              cmd_wr;
	cmd_t              cmd_in;
	logic              cmd_full;
	logic              cmd_rd;
	cmd_t              cmd_out;
	logic              cmd_empty;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	pfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.expr_char (expr_char),
		.cmd_wr    (cmd_wr),
		.cmd       (cmd_in),
		.cmd_full  (cmd_full)
	);

	pfe_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_wr),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd_en   (cmd_rd),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	pfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_rd    (cmd_rd),
		.cmd       (cmd_out),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	pfe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	pfe_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ----- hw/rtl/pfe_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module pfe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/pfe_front.sv -----
// Front end: accepts characters, builds numbers and issues stack commands.
`timescale 1ns / 1ps

module pfe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  pfe_pkg::in_item_t expr_char,
	output logic              cmd_wr,
	output pfe_pkg::cmd_t     cmd,
	input  logic              cmd_full
);

	import pfe_pkg::*;

	logic              accept;
	logic              is_digit;
	logic              is_space;
	logic [3:0]        digit;
	logic [7:0]        digit_full;
	logic [DATA_W-1:0] acc_q;
	logic              pending_q;
	logic [DATA_W-1:0] acc_next;
	logic              pend_next;
	logic              flush;
	op_t               op;

	assign full       = cmd_full;
	assign accept     = push && !cmd_full;
	assign is_digit   = (expr_char.char_code >= CH_ZERO) && (expr_char.char_code <= CH_NINE);
	assign is_space   = (expr_char.char_code == CH_SPACE);
	assign digit_full = expr_char.char_code - CH_ZERO;
	assign digit      = digit_full[3:0];

	always_comb begin
		unique case (expr_char.char_code)
			CH_PLUS:  op = OP_ADD;
			CH_MINUS: op = OP_SUB;
			CH_STAR:  op = OP_MUL;
			CH_SLASH: op = OP_DIV;
			default:  op = OP_NONE;
		endcase
	end

	assign acc_next  = is_digit ? ((acc_q << 3) + (acc_q << 1) + DATA_W'(digit)) : acc_q;
	assign pend_next = is_digit || pending_q;
	assign flush     = is_space || (op != OP_NONE) || expr_char.end_of_expression;

	assign cmd.push_valid = pend_next && flush;
	assign cmd.push_value = acc_next;
	assign cmd.op         = op;
	assign cmd.end_flag   = expr_char.end_of_expression;
	assign cmd_wr         = accept && (cmd.push_valid || (op != OP_NONE) || cmd.end_flag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			pending_q <= 1'b0;
		end else if (accept) begin
			if (cmd.push_valid || expr_char.end_of_expression) begin
				acc_q     <= '0;
				pending_q <= 1'b0;
			end else begin
				acc_q     <= acc_next;
				pending_q <= pend_next;
			end
		end
	end

endmodule

// ----- hw/rtl/pfe_cmd_fifo.sv -----
// Short command queue between the front end and the stack engine.
`timescale 1ns / 1ps

module pfe_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  pfe_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output pfe_pkg::cmd_t rd_data,
	output logic          empty
);

	import pfe_pkg::*;

	cmd_t                  entry_q [CMD_FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full    = (cnt_q == FIFO_CNT_W'(CMD_FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/pfe_div.sv -----
// Radix-2 signed divider, truncating toward zero, one quotient bit per cycle.
`timescale 1ns / 1ps

module pfe_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pfe_pkg::div_req_t req,
	output pfe_pkg::div_rsp_t rsp
);

	import pfe_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W-1:0]    dsr_q;
	logic [DATA_W:0]      shifted;
	logic [DATA_W:0]      trial;
	logic [DATA_W-1:0]    mag_dividend;
	logic [DATA_W-1:0]    mag_divisor;

	assign mag_dividend = req.dividend[DATA_W-1] ? (DATA_W'(0) - req.dividend) : req.dividend;
	assign mag_divisor  = req.divisor[DATA_W-1] ? (DATA_W'(0) - req.divisor) : req.divisor;
	assign shifted      = {rem_q, quo_q[DATA_W-1]};
	assign trial        = shifted - {1'b0, dsr_q};

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				neg_q  <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
				cnt_q  <= DIV_CNT_W'(DATA_W);
				rem_q  <= '0;
				quo_q  <= mag_dividend;
				dsr_q  <= mag_divisor;
			end else if (busy_q) begin
				if (!trial[DATA_W]) begin
					rem_q <= trial[DATA_W-1:0];
				end else begin
					rem_q <= shifted[DATA_W-1:0];
				end
				quo_q <= {quo_q[DATA_W-2:0], !trial[DATA_W]};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/pfe_back.sv -----
// Stack engine: carries out push, operator and end commands on the operand stack.
`timescale 1ns / 1ps

module pfe_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_empty,
	output logic                          cmd_rd,
	input  pfe_pkg::cmd_t                 cmd,
	output logic                          ram_we,
	output logic [pfe_pkg::ADDR_W-1:0]    ram_waddr,
	output logic [pfe_pkg::DATA_W-1:0]    ram_wdata,
	output logic [pfe_pkg::ADDR_W-1:0]    ram_raddr,
	input  logic [pfe_pkg::DATA_W-1:0]    ram_rdata,
	output pfe_pkg::div_req_t             div_req,
	input  pfe_pkg::div_rsp_t             div_rsp,
	output logic                          empty,
	input  logic                          pop,
	output pfe_pkg::out_item_t            result
);

	import pfe_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PUSH  = 6'b000010,
		ST_OP_RD = 6'b000100,
		ST_OP_EX = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_END   = 6'b100000
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [SP_W-1:0]     sp_q;
	logic [SP_W-1:0]     sp_m1;
	logic [SP_W-1:0]     sp_m2;
	logic [DATA_W-1:0]   tos_q;
	logic [1:0]          err_q;
	logic                out_valid_q;
	out_item_t           out_q;
	logic [2*DATA_W-1:0] product;
	logic [DATA_W-1:0]   op_result;
	logic                stack_full;
	logic                stack_empty;
	state_t              after_push;
	state_t              after_op;

	assign sp_m1       = sp_q - SP_W'(1);
	assign sp_m2       = sp_q - SP_W'(2);
	assign stack_full  = (sp_q == SP_W'(STACK_DEPTH));
	assign stack_empty = (sp_q == '0);

	assign cmd_rd    = (state_q == ST_IDLE) && !cmd_empty;
	assign ram_we    = (state_q == ST_PUSH) && !stack_full && !stack_empty;
	assign ram_waddr = sp_m1[ADDR_W-1:0];
	assign ram_wdata = tos_q;
	assign ram_raddr = sp_m2[ADDR_W-1:0];

	assign div_req.start    = (state_q == ST_OP_EX) && (cmd_q.op == OP_DIV) && (tos_q != '0);
	assign div_req.dividend = ram_rdata;
	assign div_req.divisor  = tos_q;

	assign empty  = !out_valid_q;
	assign result = out_q;

	assign product    = {{DATA_W{1'b0}}, ram_rdata} * {{DATA_W{1'b0}}, tos_q};
	assign after_op   = cmd_q.end_flag ? ST_END : ST_IDLE;
	assign after_push = (cmd_q.op != OP_NONE) ? ST_OP_RD : after_op;

	always_comb begin
		unique case (cmd_q.op)
			OP_ADD:  op_result = ram_rdata + tos_q;
			OP_SUB:  op_result = ram_rdata - tos_q;
			OP_MUL:  op_result = product[DATA_W-1:0];
			default: op_result = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '0;
			sp_q        <= '0;
			tos_q       <= '0;
			err_q       <= ERR_OK;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (pop && out_valid_q && (state_q != ST_END)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						cmd_q <= cmd;
						if (cmd.push_valid) begin
							state_q <= ST_PUSH;
						end else if (cmd.op != OP_NONE) begin
							state_q <= ST_OP_RD;
						end else begin
							state_q <= ST_END;
						end
					end
				end
				ST_PUSH: begin
					if (stack_full) begin
						if (err_q == ERR_OK) begin
							err_q <= ERR_OVERFLOW;
						end
					end else begin
						tos_q <= cmd_q.push_value;
						sp_q  <= sp_q + 1'b1;
					end
					state_q <= after_push;
				end
				ST_OP_RD: begin
					if (sp_q < SP_W'(2)) begin
						if (err_q == ERR_OK) begin
							err_q <= ERR_UNDERFLOW;
						end
						state_q <= after_op;
					end else begin
						state_q <= ST_OP_EX;
					end
				end
				ST_OP_EX: begin
					if (cmd_q.op != OP_DIV) begin
						tos_q   <= op_result;
						sp_q    <= sp_m1;
						state_q <= after_op;
					end else if (tos_q == '0) begin
						if (err_q == ERR_OK) begin
							err_q <= ERR_DIVZERO;
						end
						tos_q   <= '0;
						sp_q    <= sp_m1;
						state_q <= after_op;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						tos_q   <= div_rsp.quotient;
						sp_q    <= sp_m1;
						state_q <= after_op;
					end
				end
				ST_END: begin
					if (!out_valid_q || pop) begin
						out_q.value <= stack_empty ? '0 : $signed(tos_q);
						if (err_q != ERR_OK) begin
							out_q.error_code <= err_q;
						end else if (stack_empty) begin
							out_q.error_code <= ERR_UNDERFLOW;
						end else begin
							out_q.error_code <= ERR_OK;
						end
						out_valid_q <= 1'b1;
						sp_q        <= '0;
						err_q       <= ERR_OK;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/pfe_checker.sv -----
// Port-level checks of the evaluator, bound to the top level.
`timescale 1ns / 1ps

module pfe_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input pfe_pkg::in_item_t  expr_char,
	input logic               empty,
	input logic               pop,
	input pfe_pkg::out_item_t result
);

	import pfe_pkg::*;

	logic [3:0] outstanding_q;
	logic       end_in;
	logic       res_out;

	assign end_in  = push && !full && expr_char.end_of_expression;
	assign res_out = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (end_in && !res_out) begin
			outstanding_q <= outstanding_q + 1'b1;
		end else if (res_out && !end_in) begin
			outstanding_q <= outstanding_q - 1'b1;
		end
	end

	// A waiting result holds its value and error code until it is taken.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result.value) && $stable(result.error_code)))
		else $error("result changed or vanished while not popped");

	// No result appears without a closing character accepted before it.
	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (outstanding_q != '0))
		else $error("result without a matching end of expression");

	// A closing character cannot produce its result in the very next cycle.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(end_in && empty && (outstanding_q == '0)) |=> empty)
		else $error("result appeared sooner than the engine allows");

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (.*);
